// ===== sv/hevcau_pkg.sv =====
// ----------------------------------------------------------------------------
// hevcau_pkg: shared types and constants of the HEVC Annex-B AU splitter
// Placement codes, NAL type limits and the descriptor passed from the
// start-code scanner to the AU placement stage.
// ----------------------------------------------------------------------------
package hevcau_pkg;

    // Default width of the internal byte offset counters
    localparam int OFFSET_BITS_DEF = 32;
    // Width of the offsets on the result ports
    localparam int OUT_W           = 32;
    // Width of the frame period register
    localparam int PERIOD_W        = 20;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd10000;
    localparam logic [7:0]          FILLER_BYTE  = 8'hFF;

    // NAL type limits
    localparam logic [5:0] VCL_MAX_KIND = 6'd31;
    localparam logic [5:0] IDR_KIND_LO  = 6'd16;
    localparam logic [5:0] IDR_KIND_HI  = 6'd23;

    // Where a closed NAL goes
    typedef enum logic [1:0] {
        PLACE_PREFIX = 2'd0,
        PLACE_NEW_AU = 2'd1,
        PLACE_CONT   = 2'd2,
        PLACE_DROP   = 2'd3
    } t_place;

    // Descriptor of a closed NAL (or a bare end marker)
    typedef struct packed {
        logic             has_nal;
        logic [OUT_W-1:0] nal_start;
        logic [OUT_W-1:0] payload_start;
        logic [OUT_W-1:0] nal_end;
        logic [5:0]       kind;
        logic             first_slice;
        logic             stream_end;
    } t_nal_evt;

endpackage

// ===== sv/hevcau_scan.sv =====
// ----------------------------------------------------------------------------
// hevcau_scan: start-code scanner
// Tracks the byte offset and the last three bytes, finds 00 00 01 start
// codes, captures the NAL header bytes and reports each NAL as it closes.
// ----------------------------------------------------------------------------
module hevcau_scan #(
    parameter int OFFSET_BITS = hevcau_pkg::OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_emit,
    output hevcau_pkg::t_nal_evt  o_evt
);
    import hevcau_pkg::*;

    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [7:0]             r_rb0, r_rb1, r_rb2, n_rb0, n_rb1, n_rb2;
    logic                   r_open, n_open;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [OFFSET_BITS-1:0] r_pay, n_pay;
    logic [7:0]             r_hf, r_ht, n_hf, n_ht;
    logic [1:0]             r_phase, n_phase;

    logic                   w_sc;
    logic [OFFSET_BITS-1:0] w_sc_off;
    logic [OFFSET_BITS-1:0] w_pos_inc;
    logic [7:0]             w_hf, w_ht;
    logic [1:0]             w_phase;

    // Header capture for the open NAL
    always_comb begin
        w_hf    = r_hf;
        w_ht    = r_ht;
        w_phase = r_phase;
        if (r_open && r_phase != 2'd3) begin
            if (r_phase == 2'd0) begin
                w_hf = i_byte;
            end else if (r_phase == 2'd2) begin
                w_ht = i_byte;
            end
            w_phase = r_phase + 2'd1;
        end
    end

    // Start code detection; a zero before it belongs to a 4-byte code
    assign w_sc      = (r_rb1 == 8'h00) && (r_rb0 == 8'h00) && (i_byte == 8'h01);
    assign w_sc_off  = (r_rb2 == 8'h00) ? r_pos - OFFSET_BITS'(3) : r_pos - OFFSET_BITS'(2);
    assign w_pos_inc = r_pos + OFFSET_BITS'(1);

    // Descriptor of the NAL closed by this byte
    always_comb begin
        o_emit = 1'b0;
        o_evt  = '0;
        if (w_sc && r_open) begin
            o_emit              = 1'b1;
            o_evt.has_nal       = 1'b1;
            o_evt.nal_start     = OUT_W'(r_start);
            o_evt.payload_start = OUT_W'(r_pay);
            o_evt.nal_end       = OUT_W'(w_sc_off);
            o_evt.kind          = w_hf[6:1];
            o_evt.first_slice   = w_ht[7];
            o_evt.stream_end    = i_last;
        end else if (i_last) begin
            o_emit           = 1'b1;
            o_evt.stream_end = 1'b1;
            if (w_sc) begin
                // empty NAL begun by a start code on the final byte
                o_evt.has_nal       = 1'b1;
                o_evt.nal_start     = OUT_W'(w_sc_off);
                o_evt.payload_start = OUT_W'(w_pos_inc);
                o_evt.nal_end       = OUT_W'(w_pos_inc);
            end else if (r_open) begin
                o_evt.has_nal       = 1'b1;
                o_evt.nal_start     = OUT_W'(r_start);
                o_evt.payload_start = OUT_W'(r_pay);
                o_evt.nal_end       = OUT_W'(w_pos_inc);
                o_evt.kind          = w_hf[6:1];
                o_evt.first_slice   = w_ht[7];
            end
        end
    end

    // Next stream state
    always_comb begin
        n_pos   = w_pos_inc;
        n_rb0   = i_byte;
        n_rb1   = r_rb0;
        n_rb2   = r_rb1;
        n_open  = r_open;
        n_start = r_start;
        n_pay   = r_pay;
        n_hf    = w_hf;
        n_ht    = w_ht;
        n_phase = w_phase;
        if (w_sc) begin
            n_open  = 1'b1;
            n_start = w_sc_off;
            n_pay   = w_pos_inc;
            n_hf    = 8'h00;
            n_ht    = 8'h00;
            n_phase = 2'd0;
        end
        if (i_last) begin
            n_pos   = '0;
            n_rb0   = FILLER_BYTE;
            n_rb1   = FILLER_BYTE;
            n_rb2   = FILLER_BYTE;
            n_open  = 1'b0;
            n_start = '0;
            n_pay   = '0;
            n_hf    = 8'h00;
            n_ht    = 8'h00;
            n_phase = 2'd0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rb0   <= FILLER_BYTE;
            r_rb1   <= FILLER_BYTE;
            r_rb2   <= FILLER_BYTE;
            r_open  <= 1'b0;
            r_start <= '0;
            r_pay   <= '0;
            r_hf    <= 8'h00;
            r_ht    <= 8'h00;
            r_phase <= 2'd0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_rb0   <= n_rb0;
            r_rb1   <= n_rb1;
            r_rb2   <= n_rb2;
            r_open  <= n_open;
            r_start <= n_start;
            r_pay   <= n_pay;
            r_hf    <= n_hf;
            r_ht    <= n_ht;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== sv/hevcau_place.sv =====
// ----------------------------------------------------------------------------
// hevcau_place: AU placement and result register
// Places each closed NAL in an access unit, keeps the AU count, works out
// the pts and holds the finished result until the output takes it.
// ----------------------------------------------------------------------------
module hevcau_place (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  hevcau_pkg::t_nal_evt              i_evt,
    input  logic [hevcau_pkg::PERIOD_W-1:0]   i_period,
    input  logic                              i_ready,
    output logic                              o_slot_free,
    output logic                              o_valid,
    output logic                              o_has_nal,
    output logic [31:0]                       o_nal_start,
    output logic [31:0]                       o_payload_start,
    output logic [31:0]                       o_nal_end,
    output logic [5:0]                        o_nal_kind,
    output logic [1:0]                        o_placement,
    output logic [31:0]                       o_au_number,
    output logic                              o_idr,
    output logic [31:0]                       o_pts,
    output logic                              o_stream_end
);
    import hevcau_pkg::*;

    localparam int PROD_W = 32 + PERIOD_W;

    logic        r_valid;
    logic [31:0] r_au_count, n_au_count;
    logic        r_au_any, n_au_any;

    logic        r_has_nal, n_has_nal;
    logic [31:0] r_nal_start, r_payload_start, r_nal_end;
    logic [5:0]  r_kind, n_kind;
    t_place      r_place, n_place;
    logic [31:0] r_au_number, n_au_number;
    logic        r_idr, n_idr;
    logic [31:0] r_pts, n_pts;
    logic        r_stream_end;

    logic [PROD_W-1:0] w_prod;

    assign w_prod = PROD_W'(r_au_count) * PROD_W'(i_period);

    // Placement of the closed NAL
    always_comb begin
        n_has_nal   = i_evt.has_nal;
        n_kind      = i_evt.kind;
        n_place     = PLACE_PREFIX;
        n_au_number = 32'd0;
        n_idr       = 1'b0;
        n_pts       = 32'd0;
        n_au_count  = r_au_count;
        n_au_any    = r_au_any;
        if (i_evt.has_nal) begin
            if (i_evt.kind > VCL_MAX_KIND) begin
                n_place     = PLACE_PREFIX;
                n_au_number = r_au_count;
            end else if (i_evt.first_slice) begin
                n_place     = PLACE_NEW_AU;
                n_au_number = r_au_count;
                n_idr       = (i_evt.kind >= IDR_KIND_LO) && (i_evt.kind <= IDR_KIND_HI);
                n_pts       = w_prod[31:0];
                n_au_count  = r_au_count + 32'd1;
                n_au_any    = 1'b1;
            end else if (!r_au_any) begin
                n_place = PLACE_DROP;
            end else begin
                n_place     = PLACE_CONT;
                n_au_number = r_au_count - 32'd1;
            end
        end
        // end of stream returns the AU state to reset
        if (i_evt.stream_end) begin
            n_au_count = 32'd0;
            n_au_any   = 1'b0;
        end
    end

    assign o_slot_free = !r_valid || i_ready;

    // Control: result valid and AU state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_au_count <= 32'd0;
            r_au_any   <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid    <= 1'b1;
                r_au_count <= n_au_count;
                r_au_any   <= n_au_any;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_has_nal       <= n_has_nal;
            r_nal_start     <= i_evt.nal_start;
            r_payload_start <= i_evt.payload_start;
            r_nal_end       <= i_evt.nal_end;
            r_kind          <= n_kind;
            r_place         <= n_place;
            r_au_number     <= n_au_number;
            r_idr           <= n_idr;
            r_pts           <= n_pts;
            r_stream_end    <= i_evt.stream_end;
        end
    end

    assign o_valid         = r_valid;
    assign o_has_nal       = r_has_nal;
    assign o_nal_start     = r_nal_start;
    assign o_payload_start = r_payload_start;
    assign o_nal_end       = r_nal_end;
    assign o_nal_kind      = r_kind;
    assign o_placement     = r_place;
    assign o_au_number     = r_au_number;
    assign o_idr           = r_idr;
    assign o_pts           = r_pts;
    assign o_stream_end    = r_stream_end;

endmodule

// ===== sv/hevc_annexb_au_splitter.sv =====
// ----------------------------------------------------------------------------
// hevc_annexb_au_splitter: H.265 Annex-B NAL unit and access unit splitter
// Input register, start-code scanner and AU placement with result register.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle while input is not held back.
// Each byte is held in an input register, passes through the start-code
// compare, the header capture and the AU placement logic (with its 32 x 20
// bit pts multiplier) and, when it closes a NAL or ends the stream, leaves
// a descriptor in the result register. A byte that closes nothing produces
// no transaction. Input is held back only while a finished descriptor
// waits in the result register, is not taken, and the next byte would
// produce another one. The frame period register should be written
// while no byte is in flight.
// ----------------------------------------------------------------------------
module hevc_annexb_au_splitter #(
    parameter int OFFSET_BITS = hevcau_pkg::OFFSET_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [hevcau_pkg::PERIOD_W-1:0]   i_cfg_wr_data,
    // byte input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last,
    // descriptor output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_has_nal,
    output logic [31:0]                       o_nal_start,
    output logic [31:0]                       o_payload_start,
    output logic [31:0]                       o_nal_end,
    output logic [5:0]                        o_nal_kind,
    output logic [1:0]                        o_placement,
    output logic [31:0]                       o_au_number,
    output logic                              o_idr,
    output logic [31:0]                       o_pts,
    output logic                              o_stream_end
);
    import hevcau_pkg::*;

    logic [PERIOD_W-1:0] r_frame_period;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_last;

    logic                w_emit;
    logic                w_slot_free;
    logic                w_advance;
    t_nal_evt            w_evt;

    // Frame period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_period <= i_cfg_wr_data;
        end
    end

    // Flow control: the held byte moves on unless its result would find
    // the result register still full
    assign w_advance = r_in_valid && (!w_emit || w_slot_free);
    assign o_ready   = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    hevcau_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_emit  (w_emit),
        .o_evt   (w_evt)
    );

    hevcau_place u_place (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_advance && w_emit),
        .i_evt           (w_evt),
        .i_period        (r_frame_period),
        .i_ready         (i_ready),
        .o_slot_free     (w_slot_free),
        .o_valid         (o_valid),
        .o_has_nal       (o_has_nal),
        .o_nal_start     (o_nal_start),
        .o_payload_start (o_payload_start),
        .o_nal_end       (o_nal_end),
        .o_nal_kind      (o_nal_kind),
        .o_placement     (o_placement),
        .o_au_number     (o_au_number),
        .o_idr           (o_idr),
        .o_pts           (o_pts),
        .o_stream_end    (o_stream_end)
    );

    // Assertions

    // the final byte of a stream always closes with a transaction
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |-> w_emit)
        else $error("final byte produced no descriptor");

    // a loaded result is valid in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> o_valid)
        else $error("descriptor lost on load");

    // dropped NALs carry no AU number, idr or pts
    a_drop_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_nal && (o_placement == PLACE_DROP)) |->
        (o_au_number == 32'd0) && !o_idr && (o_pts == 32'd0))
        else $error("dropped NAL with AU fields set");

    // idr only on a new AU
    a_idr_new_au: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idr) |-> (o_has_nal && (o_placement == PLACE_NEW_AU)))
        else $error("idr outside an AU start");

    // a bare end marker carries only the end flag
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_nal) |-> (o_stream_end && (o_nal_start == 32'd0)
        && (o_payload_start == 32'd0) && (o_nal_end == 32'd0)
        && (o_nal_kind == 6'd0) && (o_placement == PLACE_PREFIX)
        && (o_au_number == 32'd0) && !o_idr && (o_pts == 32'd0)))
        else $error("bare end marker with fields set");

endmodule
